/* hdl/amm_pkg.sv */
// Shared types and constants of the audio matrix mixer.
// Used by every module of the mixer; depends on nothing.
`timescale 1ns / 1ps

package amm_pkg;

  // Beat kinds carried in tuser of the input stream.
  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_MIX  = 1'b1
  } cmd_e;

  localparam int unsigned IN_CHANNELS_DEF  = 4;
  localparam int unsigned OUT_CHANNELS_DEF = 4;

  localparam int unsigned SAMPLE_FIELDS = 4;   // sample fields in an input beat
  localparam int unsigned OUT_FIELDS    = 4;   // mix fields in an output beat
  localparam int unsigned IDX_W         = 3;
  localparam int unsigned SAMPLE_W      = 24;
  localparam int unsigned GAIN_W        = 16;
  localparam int unsigned PROD_W        = SAMPLE_W + GAIN_W;
  localparam int unsigned FRAC_SHIFT    = 12;

  localparam int unsigned IN_FIELDS_W   = 2 * IDX_W + GAIN_W + SAMPLE_FIELDS * SAMPLE_W;
  localparam int unsigned OUT_FIELDS_W  = OUT_FIELDS * SAMPLE_W + OUT_FIELDS;
  localparam int unsigned TDATA_IN_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned TDATA_OUT_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [GAIN_W-1:0]   gain_t;
  typedef logic signed [PROD_W-1:0]   prod_t;

endpackage

/* hdl/audio_matrix_mixer_clip_top.sv */
// Top level of the audio matrix mixer with output clipping.
// Depends on amm_pkg, amm_mult, amm_sum and amm_sat.
`timescale 1ns / 1ps

// The mixer takes beats on a slave stream and returns results on a master
// stream. An input beat whose tuser is the load kind writes one Q4.12 gain
// into the table at [gain_row][gain_col] and produces no output beat; loads
// outside the matrix are dropped. An input beat of the mix kind carries one
// Q1.23 sample per input channel and produces exactly one output beat with
// one saturated Q1.23 sample per output channel and a clip mask.
// The datapath is four register stages: products of every gain with every
// sample, pairwise sums, the final sum per output, and the shift, saturate
// and output register. m_axis_tvalid rises once an accepted mix beat has
// passed all four registers in that order. One beat is accepted in every
// cycle while the receiver keeps taking results; the rate is set by
// the product stage, which holds one multiplier per matrix entry.
// Every stage holds its own valid bit and loads only when its successor
// frees up, so when the receiver stalls the pipeline fills and tready falls
// without losing or repeating a beat. Reset clears the gain table to zero
// and empties the pipeline.
module audio_matrix_mixer_clip_top #(
  parameter int unsigned IN_CHANNELS  = amm_pkg::IN_CHANNELS_DEF,
  parameter int unsigned OUT_CHANNELS = amm_pkg::OUT_CHANNELS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // gain_row, gain_col, gain_value, sample_in_0 .. sample_in_3, zero fill
  input  logic [amm_pkg::TDATA_IN_W-1:0]    s_axis_tdata,
  // command
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // mix_out_0 .. mix_out_3, clip_mask, zero fill
  output logic [amm_pkg::TDATA_OUT_W-1:0]   m_axis_tdata
);
  import amm_pkg::*;

  // Pairwise sums first, then one group that holds all partial sums.
  localparam int unsigned PAIRS = (IN_CHANNELS + 1) / 2;
  localparam int unsigned PAIR_W = PROD_W + 1;
  localparam int unsigned SUM_W = PAIR_W + $clog2(PAIRS);

  localparam int unsigned ROW_LSB    = 0;
  localparam int unsigned COL_LSB    = ROW_LSB + IDX_W;
  localparam int unsigned GAIN_LSB   = COL_LSB + IDX_W;
  localparam int unsigned SAMPLE_LSB = GAIN_LSB + GAIN_W;
  localparam int unsigned CLIP_LSB   = OUT_FIELDS * SAMPLE_W;

  cmd_e                    cmd;
  sample_t                 sample_in [SAMPLE_FIELDS];
  prod_t                   prod      [OUT_CHANNELS][IN_CHANNELS];
  logic signed [PAIR_W-1:0] pair_sum [OUT_CHANNELS][PAIRS];
  logic signed [SUM_W-1:0]  full_sum [OUT_CHANNELS][1];
  logic signed [SUM_W-1:0]  sat_in   [OUT_CHANNELS];
  sample_t                 mix_out   [OUT_FIELDS];
  logic [OUT_FIELDS-1:0]   clip_mask;

  logic prod_valid, prod_ready;
  logic pair_valid, pair_ready;
  logic sum_valid,  sum_ready;

  assign cmd = cmd_e'(s_axis_tuser);

  for (genvar gs = 0; gs < SAMPLE_FIELDS; gs++) begin : g_unpack
    assign sample_in[gs] = s_axis_tdata[SAMPLE_LSB + gs * SAMPLE_W +: SAMPLE_W];
  end

  amm_mult #(
    .IN_CHANNELS  (IN_CHANNELS),
    .OUT_CHANNELS (OUT_CHANNELS)
  ) u_mult (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .cmd_i        (cmd),
    .gain_row_i   (s_axis_tdata[ROW_LSB +: IDX_W]),
    .gain_col_i   (s_axis_tdata[COL_LSB +: IDX_W]),
    .gain_value_i (s_axis_tdata[GAIN_LSB +: GAIN_W]),
    .sample_i     (sample_in),
    .out_valid_o  (prod_valid),
    .out_ready_i  (prod_ready),
    .prod_o       (prod)
  );

  amm_sum #(
    .LANES  (OUT_CHANNELS),
    .NUM_IN (IN_CHANNELS),
    .GROUP  (2),
    .IN_W   (PROD_W),
    .OUT_W  (PAIR_W)
  ) u_pair (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (prod_valid),
    .in_ready_o  (prod_ready),
    .din_i       (prod),
    .out_valid_o (pair_valid),
    .out_ready_i (pair_ready),
    .dout_o      (pair_sum)
  );

  amm_sum #(
    .LANES  (OUT_CHANNELS),
    .NUM_IN (PAIRS),
    .GROUP  (PAIRS),
    .IN_W   (PAIR_W),
    .OUT_W  (SUM_W)
  ) u_total (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pair_valid),
    .in_ready_o  (pair_ready),
    .din_i       (pair_sum),
    .out_valid_o (sum_valid),
    .out_ready_i (sum_ready),
    .dout_o      (full_sum)
  );

  for (genvar go = 0; go < OUT_CHANNELS; go++) begin : g_lane
    assign sat_in[go] = full_sum[go][0];
  end

  amm_sat #(
    .OUT_CHANNELS (OUT_CHANNELS),
    .SUM_W        (SUM_W)
  ) u_sat (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sum_valid),
    .in_ready_o  (sum_ready),
    .sum_i       (sat_in),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .mix_o       (mix_out),
    .clip_o      (clip_mask)
  );

  for (genvar gp = 0; gp < OUT_FIELDS; gp++) begin : g_pack
    assign m_axis_tdata[gp * SAMPLE_W +: SAMPLE_W] = mix_out[gp];
  end
  assign m_axis_tdata[CLIP_LSB +: OUT_FIELDS] = clip_mask;
  assign m_axis_tdata[TDATA_OUT_W-1:OUT_FIELDS_W] = '0;

endmodule

/* hdl/amm_mult.sv */
// Gain table and product stage of the audio matrix mixer.
// Depends on amm_pkg.
`timescale 1ns / 1ps

module amm_mult #(
  parameter int unsigned IN_CHANNELS  = amm_pkg::IN_CHANNELS_DEF,
  parameter int unsigned OUT_CHANNELS = amm_pkg::OUT_CHANNELS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  amm_pkg::cmd_e       cmd_i,
  input  logic [2:0]          gain_row_i,
  input  logic [2:0]          gain_col_i,
  input  amm_pkg::gain_t      gain_value_i,
  input  amm_pkg::sample_t    sample_i [amm_pkg::SAMPLE_FIELDS],
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output amm_pkg::prod_t      prod_o [OUT_CHANNELS][IN_CHANNELS]
);
  import amm_pkg::*;

  gain_t   gain_q [IN_CHANNELS][OUT_CHANNELS];
  sample_t samp   [IN_CHANNELS];
  prod_t   prod_q [OUT_CHANNELS][IN_CHANNELS];
  logic    valid_q;
  logic    accept;

  // Channels beyond the sample fields of a beat contribute silence.
  for (genvar gi = 0; gi < IN_CHANNELS; gi++) begin : g_samp
    if (gi < SAMPLE_FIELDS) begin : g_field
      assign samp[gi] = sample_i[gi];
    end else begin : g_zero
      assign samp[gi] = '0;
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // A load to a row or column outside the matrix matches no entry and is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < IN_CHANNELS; r++) begin
        for (int c = 0; c < OUT_CHANNELS; c++) begin
          gain_q[r][c] <= '0;
        end
      end
    end else if (accept && cmd_i == CMD_LOAD) begin
      for (int r = 0; r < IN_CHANNELS; r++) begin
        for (int c = 0; c < OUT_CHANNELS; c++) begin
          if (gain_row_i == IDX_W'(r) && gain_col_i == IDX_W'(c)) begin
            gain_q[r][c] <= gain_value_i;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i && cmd_i == CMD_MIX;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && cmd_i == CMD_MIX) begin
      for (int o = 0; o < OUT_CHANNELS; o++) begin
        for (int i = 0; i < IN_CHANNELS; i++) begin
          prod_q[o][i] <= samp[i] * gain_q[i][o];
        end
      end
    end
  end

  assign out_valid_o = valid_q;
  assign prod_o      = prod_q;

endmodule

/* hdl/amm_sum.sv */
// Registered adder stage of the audio matrix mixer: sums groups of terms per lane.
// Depends on amm_pkg.
`timescale 1ns / 1ps

module amm_sum #(
  parameter int unsigned LANES   = amm_pkg::OUT_CHANNELS_DEF,
  parameter int unsigned NUM_IN  = amm_pkg::IN_CHANNELS_DEF,
  parameter int unsigned GROUP   = 2,
  parameter int unsigned IN_W    = amm_pkg::PROD_W,
  parameter int unsigned OUT_W   = amm_pkg::PROD_W + 1,
  localparam int unsigned NUM_GRP = (NUM_IN + GROUP - 1) / GROUP
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [IN_W-1:0]  din_i  [LANES][NUM_IN],
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [OUT_W-1:0] dout_o [LANES][NUM_GRP]
);
  import amm_pkg::*;

  logic signed [OUT_W-1:0] sum_d [LANES][NUM_GRP];
  logic signed [OUT_W-1:0] sum_q [LANES][NUM_GRP];
  logic                    valid_q;

  always_comb begin
    logic signed [OUT_W-1:0] acc;
    acc = '0;
    for (int l = 0; l < LANES; l++) begin
      for (int g = 0; g < NUM_GRP; g++) begin
        acc = '0;
        for (int k = 0; k < GROUP; k++) begin
          if (g * GROUP + k < NUM_IN) begin
            acc = acc + OUT_W'(din_i[l][g * GROUP + k]);
          end
        end
        sum_d[l][g] = acc;
      end
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      sum_q <= sum_d;
    end
  end

  assign out_valid_o = valid_q;
  assign dout_o      = sum_q;

endmodule

/* hdl/amm_sat.sv */
// Output stage of the audio matrix mixer: floor shift, saturation and clip flags,
// held in the output register. Depends on amm_pkg.
`timescale 1ns / 1ps

module amm_sat #(
  parameter int unsigned OUT_CHANNELS = amm_pkg::OUT_CHANNELS_DEF,
  parameter int unsigned SUM_W        = amm_pkg::PROD_W + 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [SUM_W-1:0] sum_i [OUT_CHANNELS],
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output amm_pkg::sample_t        mix_o [amm_pkg::OUT_FIELDS],
  output logic [amm_pkg::OUT_FIELDS-1:0] clip_o
);
  import amm_pkg::*;

  localparam int unsigned TOP_LSB = FRAC_SHIFT + SAMPLE_W - 1;

  sample_t                mix_d [OUT_FIELDS];
  sample_t                mix_q [OUT_FIELDS];
  logic [OUT_FIELDS-1:0]  clip_d;
  logic [OUT_FIELDS-1:0]  clip_q;
  logic                   valid_q;

  // Dropping the low bits is a floor shift; the result fits when all bits
  // above the new sign bit agree with it.
  for (genvar go = 0; go < OUT_FIELDS; go++) begin : g_out
    if (go < OUT_CHANNELS) begin : g_chan
      logic fits;
      assign fits = (&sum_i[go][SUM_W-1:TOP_LSB]) || !(|sum_i[go][SUM_W-1:TOP_LSB]);
      assign clip_d[go] = !fits;
      assign mix_d[go]  = fits ? sum_i[go][TOP_LSB:FRAC_SHIFT]
                        : (sum_i[go][SUM_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                              : {1'b0, {(SAMPLE_W-1){1'b1}}});
    end else begin : g_absent
      assign clip_d[go] = 1'b0;
      assign mix_d[go]  = '0;
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      mix_q  <= mix_d;
      clip_q <= clip_d;
    end
  end

  assign out_valid_o = valid_q;
  assign mix_o       = mix_q;
  assign clip_o      = clip_q;

endmodule
